FILE: rtl/ihrl_pkg.sv
// Shared types, constants and helpers for the Intel HEX record loader.
`timescale 1ns / 1ps
`default_nettype none
package ihrl_pkg;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] HEX_ADJUST = 8'd7;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_COUNT = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] offset;
    logic [7:0]  data_byte;
    logic [15:0] start_address;
    logic [16:0] span_length;
  } result_t;

  // Lenient digit decode: letters fold down by 7, only the low nibble survives.
  function automatic logic [3:0] hex_digit(input logic [7:0] ch);
    logic [7:0] t;
    t = ch - CHAR_ZERO;
    if (t > 8'd9 && t < 8'd128) begin
      t = t - HEX_ADJUST;
    end
    return t[3:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ihrl_core.sv
// Record parser: field state machine, address tracking and result build.
`timescale 1ns / 1ps
`default_nettype none
module ihrl_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire logic [7:0]       character,
  output logic                  res_valid,
  output ihrl_pkg::result_t     res
);
  import ihrl_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  digit_cnt_r, digit_cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  rec_count_r, rec_count_nxt;
  logic [15:0] rec_addr_r, rec_addr_nxt;
  logic [7:0]  data_idx_r, data_idx_nxt;
  logic [15:0] first_addr_r, first_addr_nxt;
  logic        first_seen_r, first_seen_nxt;
  logic [16:0] high_end_r, high_end_nxt;

  logic [15:0] acc_shift;
  logic [2:0]  cnt_inc;
  logic [2:0]  need;
  logic        field_done;
  logic [16:0] rec_end;
  logic [7:0]  idx_inc;
  result_t     end_res;

  always_comb begin
    acc_shift  = {acc_r[11:0], hex_digit(character)};
    cnt_inc    = digit_cnt_r + 3'd1;
    need       = (phase_r == PH_ADDR) ? 3'd4 : 3'd2;
    field_done = (cnt_inc >= need);
    rec_end    = {1'b0, acc_shift} + {9'd0, rec_count_r};
    idx_inc    = data_idx_r + 8'd1;

    end_res.kind          = KIND_END;
    end_res.offset        = '0;
    end_res.data_byte     = '0;
    end_res.start_address = first_addr_r;
    end_res.span_length   = high_end_r - {1'b0, first_addr_r};

    phase_nxt      = phase_r;
    digit_cnt_nxt  = digit_cnt_r;
    acc_nxt        = acc_r;
    rec_count_nxt  = rec_count_r;
    rec_addr_nxt   = rec_addr_r;
    data_idx_nxt   = data_idx_r;
    first_addr_nxt = first_addr_r;
    first_seen_nxt = first_seen_r;
    high_end_nxt   = high_end_r;
    res_valid      = 1'b0;
    res            = end_res;

    case (phase_r)
      PH_DONE: begin
      end
      PH_WAIT: begin
        if (character == CHAR_COLON) begin
          phase_nxt     = PH_COUNT;
          digit_cnt_nxt = '0;
          acc_nxt       = '0;
        end
      end
      PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
        acc_nxt       = acc_shift;
        digit_cnt_nxt = cnt_inc;
        if (field_done) begin
          digit_cnt_nxt = '0;
          acc_nxt       = '0;
          case (phase_r)
            PH_COUNT: begin
              rec_count_nxt = acc_shift[7:0];
              if (acc_shift[7:0] == 8'd0) begin
                res_valid = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_ADDR;
              end
            end
            PH_ADDR: begin
              rec_addr_nxt = acc_shift;
              if (rec_end > high_end_r) begin
                high_end_nxt = rec_end;
              end
              if (!first_seen_r) begin
                first_addr_nxt = acc_shift;
                first_seen_nxt = 1'b1;
              end
              phase_nxt = PH_TYPE;
            end
            PH_TYPE: begin
              if (acc_shift[7:0] != 8'd0) begin
                res_valid = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                data_idx_nxt = '0;
                phase_nxt    = PH_DATA;
              end
            end
            PH_DATA: begin
              res_valid         = 1'b1;
              res.kind          = KIND_DATA;
              res.offset        = rec_addr_r + {8'd0, data_idx_r} - first_addr_r;
              res.data_byte     = acc_shift[7:0];
              res.start_address = '0;
              res.span_length   = '0;
              data_idx_nxt      = idx_inc;
              if (idx_inc >= rec_count_r) begin
                phase_nxt = PH_CSUM;
              end
            end
            default: begin
              phase_nxt = PH_WAIT;
            end
          endcase
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      digit_cnt_r  <= '0;
      acc_r        <= '0;
      rec_count_r  <= '0;
      rec_addr_r   <= '0;
      data_idx_r   <= '0;
      first_addr_r <= '0;
      first_seen_r <= 1'b0;
      high_end_r   <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      digit_cnt_r  <= digit_cnt_nxt;
      acc_r        <= acc_nxt;
      rec_count_r  <= rec_count_nxt;
      rec_addr_r   <= rec_addr_nxt;
      data_idx_r   <= data_idx_nxt;
      first_addr_r <= first_addr_nxt;
      first_seen_r <= first_seen_nxt;
      high_end_r   <= high_end_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/intel_hex_record_loader.sv
// Top level of the Intel HEX record loader: handshakes and result register.
//
//  channel  dir  handshake             payload
//  in_      in   in_valid / in_ready   in_character[7:0]
//  out_     out  out_valid / out_ready out_kind, out_offset, out_data_byte,
//                                      out_start_address, out_span_length
//
// One character is taken per cycle; its result, if any, shows in the
// output register on the next cycle. The parser state updates in the same
// cycle as the transfer. A new character is taken whenever the output
// register is empty or is being drained in that cycle, so a stalled
// output holds the input only while a result is pending. Synchronous
// reset returns the parser to waiting for a colon and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module intel_hex_record_loader (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_character,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [15:0]      out_offset,
  output logic [7:0]       out_data_byte,
  output logic [15:0]      out_start_address,
  output logic [16:0]      out_span_length
);
  import ihrl_pkg::*;

  logic    step_en;
  logic    res_valid;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  assign in_ready = !out_valid_r || out_ready;
  assign step_en  = in_valid && in_ready;

  ihrl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .character (in_character),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (step_en && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_offset        = out_res_r.offset;
  assign out_data_byte     = out_res_r.data_byte;
  assign out_start_address = out_res_r.start_address;
  assign out_span_length   = out_res_r.span_length;

endmodule
`default_nettype wire
